### hdl/lzbd_pkg.sv
// Shared types, constants and functions of the LZ bitstream decompressor.
package lzbd_pkg;

   localparam int HIST_DEPTH = 4096;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int OUT_LANES  = 8;
   localparam int LANE_CW    = $clog2(OUT_LANES + 1);
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef enum logic [1:0] {
      CSR_UNPACKED_LENGTH = 2'd0,
      CSR_DECRYPT_KEY     = 2'd1,
      CSR_EXPECTED_CRC    = 2'd2
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_CRC_BAD  = 2'd1,
      ST_KEY_ZERO = 2'd2
   } status_code_type;

   typedef enum logic [4:0] {
      PH_FLAG0  = 5'd0,  PH_FLAG1 = 5'd1,  PH_TOK    = 5'd2,  PH_LIT   = 5'd3,
      PH_T1     = 5'd4,  PH_T2    = 5'd5,  PH_SHORT  = 5'd6,  PH_T3    = 5'd7,
      PH_LONG   = 5'd8,  PH_ENDBIT = 5'd9, PH_MC0    = 5'd10, PH_MC1   = 5'd11,
      PH_MC2    = 5'd12, PH_RL0   = 5'd13, PH_RL1    = 5'd14, PH_RL2   = 5'd15,
      PH_RL3    = 5'd16, PH_RUN   = 5'd17, PH_OFF0   = 5'd18, PH_OFF1  = 5'd19,
      PH_OFF2   = 5'd20, PH_OFF3  = 5'd21, PH_OFF4   = 5'd22, PH_OFF5  = 5'd23,
      PH_OFF6   = 5'd24, PH_OFFRAW = 5'd25
   } phase_type;

   typedef enum logic [2:0] {
      CS_IDLE, CS_RUN, CS_CRD, CS_CEM, CS_TAIL, CS_FIN
   } ctrl_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_KEY_LOAD, OP_CR_SET3, OP_CR_MC0, OP_CR_MC2, OP_LR_SHIFT,
      OP_LR_DONE, OP_CD_CLR, OP_CD_BIT, OP_CD_OFF3, OP_CD_OFF4, OP_CD_OFF6,
      OP_LIT, OP_SHORT, OP_LONG, OP_RUN, OP_OFFRAW, OP_COPY
   } dp_op_type;

   typedef struct packed {
      logic            load_byte;
      logic            take_bit;
      dp_op_type       op;
      logic            hist_rd;
      logic            push;
      logic            push_fin;
      logic            push_last;
      status_code_type status;
   } dp_cmd_type;

   typedef struct packed {
      logic bit_now;
      logic bits_empty;
      logic byte_zero;
      logic key_zero;
      logic len_done;
      logic crc_match;
      logic mc2_nine;
      logic cd_zero;
      logic lr_last;
      logic cr_one;
      logic lane_full;
      logic lane_empty;
      logic out_free;
   } dp_stat_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### hdl/lzbd_ifs.sv
// Valid/ready channel interfaces for packed input bytes and decoded results.
interface lzbd_req_if import lzbd_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] packed_byte;
   modport source (output valid, output packed_byte, input ready);
   modport sink (input valid, input packed_byte, output ready);
endinterface

interface lzbd_rsp_if import lzbd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [8*OUT_LANES-1:0] out_bytes;
   logic [3:0]             out_count;
   logic                   run_last;
   logic                   finished;
   logic [1:0]             status;
   logic [15:0]            crc_value;
   modport source (output valid, output out_bytes, output out_count, output run_last,
                   output finished, output status, output crc_value, input ready);
   modport sink (input valid, input out_bytes, input out_count, input run_last,
                 input finished, input status, input crc_value, output ready);
endinterface

### hdl/lzbd_ctrl.sv
// Decoder controller: token phase machine and per-beat sequencing.
module lzbd_ctrl import lzbd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctrl_state_type  state_ff, state_in;
   phase_type       phase_ff, phase_in;
   logic            have_ff, have_in;
   logic            halted_ff, halted_in;
   logic            end_ff, end_in;
   status_code_type end_st_ff, end_st_in;
   logic            raw_ph, b;

   assign raw_ph = (phase_ff == PH_LIT) || (phase_ff == PH_SHORT) || (phase_ff == PH_LONG) ||
                   (phase_ff == PH_RUN) || (phase_ff == PH_OFFRAW);
   assign b = stat.bit_now;

   // actions and decoder phase
   always_comb begin
      cmd       = '0;
      cmd.op    = OP_NONE;
      cmd.status = ST_OK;
      req_ready = 1'b0;
      phase_in  = phase_ff;
      have_in   = have_ff;
      halted_in = halted_ff;
      end_in    = end_ff;
      end_st_in = end_st_ff;
      case (state_ff)
         CS_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_byte = req_valid;
            if (req_valid && !halted_ff) have_in = 1'b1;
         end
         CS_RUN: begin
            if (halted_ff) begin
            end else if (raw_ph) begin
               if (have_ff) begin
                  case (phase_ff)
                     PH_LIT, PH_RUN: begin
                        if (stat.lane_full) begin
                           cmd.push = stat.out_free;
                        end else begin
                           have_in = 1'b0;
                           cmd.op  = (phase_ff == PH_LIT) ? OP_LIT : OP_RUN;
                           if (phase_ff == PH_LIT || stat.lr_last) phase_in = PH_TOK;
                        end
                     end
                     PH_SHORT: begin
                        have_in = 1'b0; cmd.op = OP_SHORT; phase_in = PH_TOK;
                     end
                     PH_LONG: begin
                        have_in = 1'b0;
                        if (stat.byte_zero) begin
                           phase_in = PH_ENDBIT;
                        end else begin
                           cmd.op = OP_LONG; phase_in = PH_OFF0;
                        end
                     end
                     default: begin
                        have_in = 1'b0; cmd.op = OP_OFFRAW; phase_in = PH_TOK;
                     end
                  endcase
               end
            end else if (!stat.bits_empty || have_ff) begin
               cmd.take_bit = 1'b1;
               if (stat.bits_empty) have_in = 1'b0;
               case (phase_ff)
                  PH_FLAG0: phase_in = PH_FLAG1;
                  PH_FLAG1, PH_ENDBIT: begin
                     if (phase_ff == PH_FLAG1) cmd.op = OP_KEY_LOAD;
                     if (phase_ff == PH_FLAG1 && b && stat.key_zero) begin
                        halted_in = 1'b1; end_in = 1'b1; end_st_in = ST_KEY_ZERO;
                     end else if (stat.len_done) begin
                        halted_in = 1'b1; end_in = 1'b1;
                        end_st_in = stat.crc_match ? ST_OK : ST_CRC_BAD;
                     end else begin
                        phase_in = PH_TOK;
                     end
                  end
                  PH_TOK: phase_in = b ? PH_T1 : PH_LIT;
                  PH_T1:  phase_in = b ? PH_T2 : PH_MC0;
                  PH_T2:  phase_in = b ? PH_T3 : PH_SHORT;
                  PH_T3: begin
                     if (b) begin
                        phase_in = PH_LONG;
                     end else begin
                        cmd.op = OP_CR_SET3; phase_in = PH_OFF0;
                     end
                  end
                  PH_MC0: begin cmd.op = OP_CR_MC0; phase_in = PH_MC1; end
                  PH_MC1: phase_in = b ? PH_MC2 : PH_OFF0;
                  PH_MC2: begin
                     cmd.op = OP_CR_MC2; phase_in = stat.mc2_nine ? PH_RL0 : PH_OFF0;
                  end
                  PH_OFF0: begin cmd.op = OP_CD_CLR; phase_in = b ? PH_OFF1 : PH_OFFRAW; end
                  PH_OFF1: begin cmd.op = OP_CD_BIT; phase_in = PH_OFF2; end
                  PH_OFF2: begin
                     if (b) phase_in = PH_OFF3;
                     else phase_in = stat.cd_zero ? PH_OFF4 : PH_OFFRAW;
                  end
                  PH_OFF3: begin cmd.op = OP_CD_OFF3; phase_in = PH_OFF5; end
                  PH_OFF4: begin cmd.op = OP_CD_OFF4; phase_in = PH_OFFRAW; end
                  PH_OFF5: phase_in = b ? PH_OFFRAW : PH_OFF6;
                  PH_OFF6: begin cmd.op = OP_CD_OFF6; phase_in = PH_OFFRAW; end
                  PH_RL0:  begin cmd.op = OP_LR_SHIFT; phase_in = PH_RL1; end
                  PH_RL1:  begin cmd.op = OP_LR_SHIFT; phase_in = PH_RL2; end
                  PH_RL2:  begin cmd.op = OP_LR_SHIFT; phase_in = PH_RL3; end
                  PH_RL3:  begin cmd.op = OP_LR_DONE; phase_in = PH_RUN; end
                  default: phase_in = phase_ff;
               endcase
            end
         end
         CS_CRD: cmd.hist_rd = 1'b1;
         CS_CEM: begin
            if (stat.lane_full) cmd.push = stat.out_free;
            else cmd.op = OP_COPY;
         end
         CS_TAIL: begin
            if (!stat.lane_empty) begin
               cmd.push      = stat.out_free;
               cmd.push_last = !end_ff;
            end
         end
         CS_FIN: begin
            cmd.push      = stat.out_free;
            cmd.push_fin  = 1'b1;
            cmd.push_last = 1'b1;
            cmd.status    = end_st_ff;
            if (stat.out_free) end_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // sequencing state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: if (req_valid && !halted_ff) state_in = CS_RUN;
         CS_RUN: begin
            if (halted_ff) state_in = CS_TAIL;
            else if (raw_ph && !have_ff) state_in = CS_TAIL;
            else if (!raw_ph && stat.bits_empty && !have_ff) state_in = CS_TAIL;
            else if (cmd.op == OP_SHORT || cmd.op == OP_OFFRAW) state_in = CS_CRD;
         end
         CS_CRD: state_in = CS_CEM;
         CS_CEM: if (cmd.op == OP_COPY) state_in = stat.cr_one ? CS_RUN : CS_CRD;
         CS_TAIL: begin
            if (stat.lane_empty) state_in = end_ff ? CS_FIN : CS_IDLE;
         end
         CS_FIN: if (stat.out_free) state_in = CS_IDLE;
         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= CS_IDLE;
         phase_ff  <= PH_FLAG0;
         have_ff   <= 1'b0;
         halted_ff <= 1'b0;
         end_ff    <= 1'b0;
         end_st_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         have_ff   <= have_in;
         halted_ff <= halted_in;
         end_ff    <= end_in;
         end_st_ff <= end_st_in;
      end
   end

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff) else $error("decoder left the halted state");
   a_idle_no_byte: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_IDLE) |-> !have_ff) else $error("byte left over at step end");
   a_fin_after_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_FIN) |-> (end_ff && halted_ff)) else $error("final result without end");

endmodule

### hdl/lzbd_datapath.sv
// Decoder datapath: bit holder, key, counters, history RAM, CRC and result packing.
module lzbd_datapath import lzbd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_write_data,
   input  logic [7:0]             req_byte,
   input  dp_cmd_type             cmd,
   output dp_stat_type            stat,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [8*OUT_LANES-1:0] rsp_bytes,
   output logic [3:0]             rsp_count,
   output logic                   rsp_run_last,
   output logic                   rsp_finished,
   output logic [1:0]             rsp_status,
   output logic [15:0]            rsp_crc
);

   logic [31:0]            len_ff;
   logic [15:0]            key_cfg_ff, exp_crc_ff;
   logic [7:0]             byte_ff, holder_ff, holder_in;
   logic [3:0]             bleft_ff, bleft_in;
   logic [15:0]            key_ff, key_in, crc_ff, crc_in;
   logic [31:0]            prod_ff, prod_in;
   logic [HIST_AW-1:0]     wp_ff, rd_addr;
   logic [8:0]             cr_ff, cr_in, mc2_val;
   logic [12:0]            cd_ff, cd_in;
   logic [6:0]             lr_ff, lr_in;
   logic [8*OUT_LANES-1:0] acc_ff, acc_in;
   logic [LANE_CW-1:0]     cnt_ff, cnt_in;
   logic [7:0]             hist_mem [HIST_DEPTH];
   logic [7:0]             rd_data_ff, emit_b;
   logic                   emit, b, rsp_valid_ff;
   logic [3:0]             lr_new;
   logic [15:0]            key_rot;

   assign b        = (bleft_ff == 4'd0) ? byte_ff[7] : holder_ff[7];
   assign mc2_val  = ((cr_ff - 9'd1) << 1) + {8'd0, b};
   assign lr_new   = {lr_ff[2:0], b};
   assign key_rot  = {key_ff[0], key_ff[15:1]};
   assign rd_addr  = wp_ff - cd_ff[HIST_AW-1:0];
   assign emit     = (cmd.op == OP_LIT) || (cmd.op == OP_RUN) || (cmd.op == OP_COPY);
   assign emit_b   = (cmd.op == OP_COPY) ? rd_data_ff : (byte_ff ^ key_ff[7:0]);

   always_comb begin
      stat.bit_now    = b;
      stat.bits_empty = (bleft_ff == 4'd0);
      stat.byte_zero  = (byte_ff == 8'd0);
      stat.key_zero   = (key_cfg_ff == 16'd0);
      stat.len_done   = (prod_ff >= len_ff);
      stat.crc_match  = (crc_ff == exp_crc_ff);
      stat.mc2_nine   = (mc2_val == 9'd9);
      stat.cd_zero    = (cd_ff == 13'd0);
      stat.lr_last    = (lr_ff <= 7'd1);
      stat.cr_one     = (cr_ff == 9'd1);
      stat.lane_full  = (cnt_ff == LANE_CW'(OUT_LANES));
      stat.lane_empty = (cnt_ff == '0);
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      holder_in = holder_ff;
      bleft_in  = bleft_ff;
      key_in    = key_ff;
      crc_in    = crc_ff;
      prod_in   = prod_ff;
      cr_in     = cr_ff;
      cd_in     = cd_ff;
      lr_in     = lr_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      if (cmd.take_bit) begin
         if (bleft_ff == 4'd0) begin
            holder_in = {byte_ff[6:0], 1'b0};
            bleft_in  = 4'd7;
         end else begin
            holder_in = {holder_ff[6:0], 1'b0};
            bleft_in  = bleft_ff - 4'd1;
         end
      end
      case (cmd.op)
         OP_KEY_LOAD: key_in = key_cfg_ff;
         OP_CR_SET3:  cr_in = 9'd3;
         OP_CR_MC0:   cr_in = 9'd4 + {8'd0, b};
         OP_CR_MC2: begin cr_in = mc2_val; lr_in = 7'd0; end
         OP_LR_SHIFT: lr_in = {lr_ff[5:0], b};
         OP_LR_DONE: begin
            lr_in   = {1'b0, lr_new, 2'b00} + 7'd12;
            prod_in = prod_ff + {25'd0, lr_in};
         end
         OP_CD_CLR:  cd_in = 13'd0;
         OP_CD_BIT:  cd_in = {12'd0, b};
         OP_CD_OFF3: cd_in = {cd_ff[11:0], b} | 13'd4;
         OP_CD_OFF4: cd_in = 13'd2 + {12'd0, b};
         OP_CD_OFF6: cd_in = {cd_ff[11:0], b};
         OP_LIT: begin key_in = key_rot; prod_in = prod_ff + 32'd1; end
         OP_SHORT: begin
            cr_in   = 9'd2;
            cd_in   = {5'd0, byte_ff} + 13'd1;
            prod_in = prod_ff + 32'd2;
         end
         OP_LONG: cr_in = {1'b0, byte_ff} + 9'd8;
         OP_RUN: begin
            if (lr_ff != 7'd0) lr_in = lr_ff - 7'd1;
            if (lr_ff <= 7'd1) key_in = key_rot;
         end
         OP_OFFRAW: begin
            cd_in   = {cd_ff[4:0], byte_ff} + 13'd1;
            prod_in = prod_ff + {23'd0, cr_ff};
         end
         OP_COPY: cr_in = cr_ff - 9'd1;
         default: begin
         end
      endcase
      if (emit) begin
         crc_in = crc16_byte(crc_ff, emit_b);
         acc_in[8*cnt_ff[LANE_CW-2:0] +: 8] = emit_b;
         cnt_in = cnt_ff + LANE_CW'(1);
      end
      if (cmd.push && !cmd.push_fin) begin
         acc_in = '0;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) hist_mem[wp_ff] <= emit_b;
      if (cmd.hist_rd) rd_data_ff <= hist_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_byte) byte_ff <= req_byte;
      if (cmd.push) begin
         rsp_bytes    <= cmd.push_fin ? '0 : acc_ff;
         rsp_count    <= cmd.push_fin ? 4'd0 : 4'(cnt_ff);
         rsp_run_last <= cmd.push_last;
         rsp_finished <= cmd.push_fin;
         rsp_status   <= cmd.status;
         rsp_crc      <= crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         key_cfg_ff   <= '0;
         exp_crc_ff   <= '0;
         holder_ff    <= '0;
         bleft_ff     <= '0;
         key_ff       <= '0;
         crc_ff       <= '0;
         prod_ff      <= '0;
         wp_ff        <= '0;
         cr_ff        <= '0;
         cd_ff        <= '0;
         lr_ff        <= '0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_UNPACKED_LENGTH: len_ff <= csr_write_data;
               CSR_DECRYPT_KEY:     key_cfg_ff <= csr_write_data[15:0];
               CSR_EXPECTED_CRC:    exp_crc_ff <= csr_write_data[15:0];
               default: begin
               end
            endcase
         end
         holder_ff    <= holder_in;
         bleft_ff     <= bleft_in;
         key_ff       <= key_in;
         crc_ff       <= crc_in;
         prod_ff      <= prod_in;
         if (emit) wp_ff <= wp_ff + HIST_AW'(1);
         cr_ff        <= cr_in;
         cd_ff        <= cd_in;
         lr_ff        <= lr_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= cmd.push ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_emit_full: assert property (@(posedge clock) disable iff (reset)
      emit |-> (cnt_ff < LANE_CW'(OUT_LANES))) else $error("byte emitted into full lanes");
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> stat.out_free) else $error("result pushed over a waiting one");
   a_lane_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LANE_CW'(OUT_LANES)) else $error("lane count overflow");

endmodule

### hdl/lz_bitstream_decompressor_top.sv
// Top level of the LZ bitstream decompressor: channels, controller and datapath.
// Streaming method-2 LZ decoder. Each req beat carries one packed byte; the block consumes
// it either as a refill of its MSB-first bit holder or raw, decodes as many tokens as that
// byte allows and returns the decoded bytes in rsp beats of up to eight, the last beat of
// each request flagged by run_last. A request that yields no byte returns no beat. When a
// chunk-end marker is met with the configured length reached, or the key is needed but the
// decrypt_key register is zero, a closing beat with finished set carries the status and
// the CRC-16/ARC; later requests are taken and dropped. A request is handled in steps:
// take the beat, then decode one stream bit or raw byte at a time, each match-copy byte
// as a history RAM read, then a write, push the result beats and close the request.
// Receiver stalls lengthen a request wherever a result beat waits to be pushed.
// Write the CSRs (0 unpacked_length, 1 decrypt_key, 2 expected_crc) only while idle.
module lz_bitstream_decompressor_top import lzbd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lzbd_req_if.sink    req_ch,
   lzbd_rsp_if.source  rsp_ch,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        req_ready;

   // decode control: token phases, beat sequencing, end handling
   lzbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_ch.ready = req_ready;

   // registers, history RAM, CRC and the result register
   lzbd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_byte         (req_ch.packed_byte),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_bytes        (rsp_ch.out_bytes),
      .rsp_count        (rsp_ch.out_count),
      .rsp_run_last     (rsp_ch.run_last),
      .rsp_finished     (rsp_ch.finished),
      .rsp_status       (rsp_ch.status),
      .rsp_crc          (rsp_ch.crc_value)
   );

endmodule

### tb/tb_lz_bitstream_decompressor_top.sv
// Self-checking testbench for the LZ bitstream decompressor top level.
module tb_lz_bitstream_decompressor_top;
   import lzbd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 20000;  // cycles with no beat before giving up
   localparam int SETTLE_TICKS = 600;    // settling wait after drain, sized for the longest request
   localparam int STREAM_LEN   = 470;

   typedef enum logic [1:0] {TK_LIT, TK_RUN, TK_COPY, TK_MARK} token_kind_type;

   typedef struct {
      token_kind_type kind;
      int             len;   // copy length, or run code 0..15
      int             back_dist;
      logic [7:0]     val;
   } token_row_type;

   typedef struct {
      logic [63:0] bytes;
      logic [3:0]  count;
      logic        last;
      logic        fin;
      logic [1:0]  status;
      logic [15:0] crc;
   } out_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_UNPACKED_LENGTH;
   logic [31:0] csr_write_data = '0;

   lzbd_req_if req_if ();
   lzbd_rsp_if rsp_if ();

   lz_bitstream_decompressor_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if.sink),
      .rsp_ch           (rsp_if.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Decoder model: own copy of the registers and the decoding state
   // ---------------------------------------------------------------------
   logic [31:0] cfg_length;
   logic [15:0] cfg_key;
   logic [15:0] cfg_crc;

   logic [7:0]  dec_hold;
   int          dec_left;
   logic [15:0] dec_key;
   logic [15:0] dec_crc;
   logic [31:0] dec_total;
   logic [7:0]  dec_hist [HIST_DEPTH];
   logic [11:0] dec_wpos;
   phase_type   dec_phase;
   int          dec_copy;
   int          dec_dist;
   int          dec_runlen;
   bit          dec_halt;

   logic [63:0]     lane_acc;
   int              lane_cnt;
   bit              end_now;
   status_code_type end_st;
   out_beat_type    step_beats [$];
   out_beat_type    pending_beats [$];

   function automatic void push_beat(logic [63:0] d, int c, bit fin, status_code_type st);
      out_beat_type b;
      b.bytes  = d;
      b.count  = 4'(c);
      b.last   = 1'b0;
      b.fin    = fin;
      b.status = st;
      b.crc    = dec_crc;
      step_beats.push_back(b);
   endfunction

   function automatic void flush_lanes();
      if (lane_cnt != 0) begin
         push_beat(lane_acc, lane_cnt, 1'b0, ST_OK);
         lane_acc = '0;
         lane_cnt = 0;
      end
   endfunction

   function automatic void emit_byte(logic [7:0] b);
      dec_hist[dec_wpos] = b;
      dec_wpos = dec_wpos + 12'd1;
      dec_crc = dec_crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         dec_crc = dec_crc[0] ? ((dec_crc >> 1) ^ 16'hA001) : (dec_crc >> 1);
      end
      lane_acc = lane_acc | (64'(b) << (8 * lane_cnt));
      lane_cnt++;
      if (lane_cnt >= OUT_LANES) flush_lanes();
   endfunction

   function automatic void rotate_key();
      dec_key = {dec_key[0], dec_key[15:1]};
   endfunction

   function automatic void stop_decoding(status_code_type st);
      dec_halt = 1'b1;
      end_now  = 1'b1;
      end_st   = st;
   endfunction

   function automatic void check_length();
      if (dec_total >= cfg_length) begin
         stop_decoding((dec_crc == cfg_crc) ? ST_OK : ST_CRC_BAD);
      end else begin
         dec_phase = PH_TOK;
      end
   endfunction

   function automatic void copy_back();
      int d;
      d = (dec_dist > HIST_DEPTH) ? HIST_DEPTH : dec_dist;
      dec_total = dec_total + 32'(dec_copy);
      while (dec_copy != 0) begin
         emit_byte(dec_hist[dec_wpos - 12'(d)]);
         dec_copy--;
      end
      dec_phase = PH_TOK;
   endfunction

   function automatic void route_match();
      if (dec_copy == 9) begin
         dec_runlen = 0;
         dec_phase  = PH_RL0;
      end else begin
         dec_phase = PH_OFF0;
      end
   endfunction

   function automatic void take_raw(logic [7:0] b);
      case (dec_phase)
         PH_LIT: begin
            emit_byte(b ^ dec_key[7:0]);
            rotate_key();
            dec_total = dec_total + 32'd1;
            dec_phase = PH_TOK;
         end
         PH_SHORT: begin
            dec_copy = 2;
            dec_dist = int'(b) + 1;
            copy_back();
         end
         PH_LONG: begin
            if (b == 8'h00) begin
               dec_phase = PH_ENDBIT;
            end else begin
               dec_copy  = int'(b) + 8;
               dec_phase = PH_OFF0;
            end
         end
         PH_RUN: begin
            emit_byte(b ^ dec_key[7:0]);
            if (dec_runlen != 0) dec_runlen--;
            if (dec_runlen == 0) begin
               rotate_key();
               dec_phase = PH_TOK;
            end
         end
         default: begin
            dec_dist = ((dec_dist << 8) | int'(b)) + 1;
            copy_back();
         end
      endcase
   endfunction

   function automatic void take_bit(bit b);
      case (dec_phase)
         PH_FLAG0: dec_phase = PH_FLAG1;
         PH_FLAG1: begin
            dec_key = cfg_key;
            if (b && cfg_key == 16'h0000) stop_decoding(ST_KEY_ZERO);
            else check_length();
         end
         PH_TOK:    dec_phase = b ? PH_T1 : PH_LIT;
         PH_T1:     dec_phase = b ? PH_T2 : PH_MC0;
         PH_T2:     dec_phase = b ? PH_T3 : PH_SHORT;
         PH_T3: begin
            if (b) begin
               dec_phase = PH_LONG;
            end else begin
               dec_copy  = 3;
               dec_phase = PH_OFF0;
            end
         end
         PH_ENDBIT: check_length();
         PH_MC0: begin
            dec_copy  = int'(b) + 4;
            dec_phase = PH_MC1;
         end
         PH_MC1: begin
            if (b) dec_phase = PH_MC2;
            else route_match();
         end
         PH_MC2: begin
            dec_copy = ((dec_copy - 1) << 1) + int'(b);
            route_match();
         end
         PH_OFF0: begin
            dec_dist  = 0;
            dec_phase = b ? PH_OFF1 : PH_OFFRAW;
         end
         PH_OFF1: begin
            dec_dist  = int'(b);
            dec_phase = PH_OFF2;
         end
         PH_OFF2: begin
            if (b) dec_phase = PH_OFF3;
            else dec_phase = (dec_dist == 0) ? PH_OFF4 : PH_OFFRAW;
         end
         PH_OFF3: begin
            dec_dist  = (dec_dist << 1) | int'(b) | 4;
            dec_phase = PH_OFF5;
         end
         PH_OFF4: begin
            dec_dist  = int'(b) + 2;
            dec_phase = PH_OFFRAW;
         end
         PH_OFF5: dec_phase = b ? PH_OFFRAW : PH_OFF6;
         PH_OFF6: begin
            dec_dist  = (dec_dist << 1) | int'(b);
            dec_phase = PH_OFFRAW;
         end
         default: begin
            // run length code, four bits MSB first
            dec_runlen = (dec_runlen << 1) | int'(b);
            if (dec_phase == PH_RL3) begin
               dec_runlen = dec_runlen * 4 + 12;
               dec_total  = dec_total + 32'(dec_runlen);
               dec_phase  = PH_RUN;
            end else begin
               dec_phase = phase_type'(dec_phase + 5'd1);
            end
         end
      endcase
   endfunction

   function automatic bit raw_wanted(phase_type p);
      return p == PH_LIT || p == PH_SHORT || p == PH_LONG || p == PH_RUN || p == PH_OFFRAW;
   endfunction

   // Decode one packed byte and queue the beats it should produce.
   function automatic void predict_byte(logic [7:0] pb);
      bit have;
      bit b;
      if (dec_halt) return;
      have     = 1'b1;
      lane_acc = '0;
      lane_cnt = 0;
      end_now  = 1'b0;
      end_st   = ST_OK;
      step_beats.delete();
      while (!dec_halt) begin
         if (raw_wanted(dec_phase)) begin
            if (!have) break;
            have = 1'b0;
            take_raw(pb);
         end else begin
            if (dec_left == 0) begin
               if (!have) break;
               have     = 1'b0;
               dec_hold = pb;
               dec_left = 8;
            end
            b        = dec_hold[7];
            dec_hold = dec_hold << 1;
            dec_left--;
            take_bit(b);
         end
      end
      flush_lanes();
      if (end_now) push_beat('0, 0, 1'b1, end_st);
      if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
      foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
   endfunction

   // ---------------------------------------------------------------------
   // Stream builder: bits fill a holder byte placed in the stream when the
   // first bit is needed, raw bytes are appended behind it
   // ---------------------------------------------------------------------
   logic [7:0] packed_stream [$];
   int         bit_slot;
   int         bit_free = 0;
   int         built_total = 0;  // bytes the stream decodes to so far
   int         cut_points [$];   // stream indexes where the CSRs are rewritten

   function automatic void put_bit(bit b);
      if (bit_free == 0) begin
         packed_stream.push_back(8'h00);
         bit_slot = packed_stream.size() - 1;
         bit_free = 8;
      end
      packed_stream[bit_slot][bit_free - 1] = b;
      bit_free--;
   endfunction

   function automatic void put_offset(int back_dist);
      int o;
      int h;
      o = back_dist - 1;
      h = o >> 8;
      if (h == 0) begin
         put_bit(0);
      end else if (h == 1) begin
         put_bit(1); put_bit(1); put_bit(0);
      end else if (h < 4) begin
         put_bit(1); put_bit(0); put_bit(0); put_bit(h[0]);
      end else if (h < 8) begin
         put_bit(1); put_bit(h[1]); put_bit(1); put_bit(h[0]); put_bit(1);
      end else begin
         put_bit(1); put_bit(h[2]); put_bit(1); put_bit(h[1]); put_bit(0); put_bit(h[0]);
      end
      packed_stream.push_back(8'(o));
   endfunction

   function automatic void put_token(token_row_type t, bit cut);
      case (t.kind)
         TK_LIT: begin
            put_bit(0);
            packed_stream.push_back(t.val);
            built_total++;
         end
         TK_RUN: begin
            put_bit(1); put_bit(0); put_bit(1); put_bit(1); put_bit(1);
            for (int i = 3; i >= 0; i--) put_bit(t.len[i]);
            for (int i = 0; i < t.len * 4 + 12; i++) packed_stream.push_back(8'($urandom));
            built_total += t.len * 4 + 12;
         end
         TK_COPY: begin
            if (t.len == 2) begin
               put_bit(1); put_bit(1); put_bit(0);
               packed_stream.push_back(8'(t.back_dist - 1));
            end else begin
               case (t.len)
                  3: begin put_bit(1); put_bit(1); put_bit(1); put_bit(0); end
                  4: begin put_bit(1); put_bit(0); put_bit(0); put_bit(0); end
                  5: begin put_bit(1); put_bit(0); put_bit(1); put_bit(0); end
                  6: begin put_bit(1); put_bit(0); put_bit(0); put_bit(1); put_bit(0); end
                  7: begin put_bit(1); put_bit(0); put_bit(0); put_bit(1); put_bit(1); end
                  8: begin put_bit(1); put_bit(0); put_bit(1); put_bit(1); put_bit(0); end
                  default: begin
                     put_bit(1); put_bit(1); put_bit(1); put_bit(1);
                     packed_stream.push_back(8'(t.len - 8));
                  end
               endcase
               put_offset(t.back_dist);
            end
            built_total += t.len;
         end
         default: begin
            // chunk end: long count byte of zero, then the end bit
            put_bit(1); put_bit(1); put_bit(1); put_bit(1);
            if (cut) cut_points.push_back(packed_stream.size());
            packed_stream.push_back(8'h00);
            put_bit(1'($urandom));
         end
      endcase
   endfunction

   function automatic token_row_type random_token();
      token_row_type t;
      int pick;
      int reach;
      pick        = $urandom_range(0, 99);
      reach       = (built_total < HIST_DEPTH) ? built_total : HIST_DEPTH;
      t.val       = 8'($urandom);
      t.back_dist = 1;
      t.len       = 0;
      if (pick < 35) begin
         t.kind = TK_LIT;
      end else if (pick < 45) begin
         t.kind = TK_RUN;
         t.len  = ($urandom_range(0, 3) == 0) ? 15 : $urandom_range(0, 15);
      end else if (pick < 97) begin
         t.kind = TK_COPY;
         t.len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 263) : $urandom_range(2, 20);
         t.back_dist = ($urandom_range(0, 1) == 0) ?
                       $urandom_range(1, (reach < 16) ? reach : 16) :
                       $urandom_range(1, reach);
         if (t.len == 2 && t.back_dist > 256) t.back_dist = $urandom_range(1, 256);
      end else begin
         t.kind = TK_MARK;
      end
      return t;
   endfunction

   // Directed tokens: literal extremes, every copy length code, short and
   // long runs, the longest copy, the farthest short reach, a chunk end
   // that does not stop decoding.
   token_row_type directed_rows [] = '{
      '{TK_LIT,  0,   1, 8'h00}, '{TK_LIT,  0,   1, 8'hFF}, '{TK_LIT,  0,   1, 8'h5A},
      '{TK_LIT,  0,   1, 8'hA5}, '{TK_COPY, 2,   1, 8'h00}, '{TK_COPY, 2,   4, 8'h00},
      '{TK_RUN,  0,   1, 8'h00}, '{TK_COPY, 3,   3, 8'h00}, '{TK_COPY, 4,  18, 8'h00},
      '{TK_COPY, 5,   1, 8'h00}, '{TK_COPY, 6,  25, 8'h00}, '{TK_COPY, 7,   2, 8'h00},
      '{TK_COPY, 8,  40, 8'h00}, '{TK_COPY, 9,   1, 8'h00}, '{TK_RUN,  15,  1, 8'h00},
      '{TK_COPY, 263, 64, 8'h00}, '{TK_COPY, 2, 256, 8'h00}, '{TK_COPY, 20, 300, 8'h00},
      '{TK_MARK, 0,   1, 8'h00}, '{TK_LIT,  0,   1, 8'h81}
   };

   // ---------------------------------------------------------------------
   // Result check, stall pattern and watchdog
   // ---------------------------------------------------------------------
   int mismatches = 0;
   int quiet_cycles = 0;
   int stall_pct = 0;
   int stall_cycle = 0;

   always @(negedge clock) begin
      // vary the receiver's appetite, sometimes never stalling
      if (stall_cycle % 64 == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 30;
            2: stall_pct = 70;
            default: stall_pct = 95;
         endcase
      end
      stall_cycle++;
      rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      out_beat_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_beats.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected beat: bytes %h count %0d", rsp_if.out_bytes,
                           rsp_if.out_count);
            end else begin
               want = pending_beats.pop_front();
               if (rsp_if.out_bytes !== want.bytes || rsp_if.out_count !== want.count ||
                   rsp_if.run_last !== want.last || rsp_if.finished !== want.fin ||
                   rsp_if.status !== want.status || rsp_if.crc_value !== want.crc) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("beat mismatch: expected bytes %h count %0d last %b fin %b",
                              want.bytes, want.count, want.last, want.fin);
                     $display("   status %0d crc %h, got bytes %h count %0d last %b",
                              want.status, want.crc, rsp_if.out_bytes, rsp_if.out_count,
                              rsp_if.run_last);
                     $display("   fin %b status %0d crc %h", rsp_if.finished,
                              rsp_if.status, rsp_if.crc_value);
                  end
               end
            end
         end
         // predict after the check so a same-edge beat meets older expectations
         if (req_if.valid && req_if.ready) predict_byte(req_if.packed_byte);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("lz_bitstream_decompressor_top regression: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   task automatic write_csr(csr_reg_type idx, logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_UNPACKED_LENGTH: cfg_length = value;
         CSR_DECRYPT_KEY:     cfg_key = value[15:0];
         default:             cfg_crc = value[15:0];
      endcase
      @(negedge clock);
   endtask

   // Send stream bytes lo..hi-1 in bursts, with or without gaps in between.
   task automatic send_bytes(int lo, int hi);
      int burst;
      int gap;
      burst = 0;
      for (int i = lo; i < hi; i++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 12);
            gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               req_if.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         burst--;
         req_if.valid       <= 1'b1;
         req_if.packed_byte <= packed_stream[i];
         @(posedge clock);
         while (!(req_if.valid && req_if.ready)) @(posedge clock);
         @(negedge clock);
      end
      req_if.valid <= 1'b0;
   endtask

   // Let every expected beat drain, then hold for the longest request.
   task automatic drain();
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      token_row_type t;
      int start_at;
      logic [15:0] first_key;

      req_if.valid       = 1'b0;
      req_if.packed_byte = 8'h00;
      rsp_if.ready       = 1'b0;

      cfg_length = '0;
      cfg_key    = '0;
      cfg_crc    = '0;
      dec_hold   = '0;
      dec_left   = 0;
      dec_key    = '0;
      dec_crc    = '0;
      dec_total  = '0;
      dec_wpos   = '0;
      dec_phase  = PH_FLAG0;
      dec_copy   = 0;
      dec_dist   = 0;
      dec_runlen = 0;
      dec_halt   = 1'b0;

      // build the whole stream first: a holder byte may carry bits of later tokens
      first_key = 16'($urandom_range(1, 65535));
      put_bit(1'($urandom));
      put_bit(1'($urandom));
      foreach (directed_rows[i]) put_token(directed_rows[i], 1'b0);
      while (packed_stream.size() < STREAM_LEN) begin
         if (cut_points.size() < 2 && packed_stream.size() > 150 * (cut_points.size() + 1))
         begin
            t.kind = TK_MARK;
            put_token(t, 1'b1);
         end else begin
            put_token(random_token(), 1'b0);
         end
      end
      t.kind = TK_MARK;
      put_token(t, 1'b1);
      // trailing bytes after the end are taken and dropped
      repeat (6) packed_stream.push_back(8'($urandom));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_csr(CSR_UNPACKED_LENGTH, 32'hFFFF_FFFF);
      write_csr(CSR_DECRYPT_KEY, {16'h0000, first_key});
      write_csr(CSR_EXPECTED_CRC, 32'h0000_0000);

      start_at = 0;
      foreach (cut_points[i]) begin
         send_bytes(start_at, cut_points[i]);
         drain();
         start_at = cut_points[i];
         if (i == 0) begin
            // key changes after the flag bits leave the rotor alone
            write_csr(CSR_DECRYPT_KEY, 32'h0000_0000);
            write_csr(CSR_EXPECTED_CRC, 32'h0000_FFFF);
            write_csr(CSR_UNPACKED_LENGTH, $urandom_range(32'h0010_0000, 32'hFFFF_FFFE));
         end else if (i == cut_points.size() - 1) begin
            write_csr(CSR_DECRYPT_KEY, 32'h0000_FFFF);
            write_csr(CSR_UNPACKED_LENGTH, ($urandom_range(0, 1) == 0) ? 32'h0 : dec_total);
            write_csr(CSR_EXPECTED_CRC,
                      {16'h0000, ($urandom_range(0, 1) == 0) ? dec_crc : ~dec_crc});
         end else begin
            write_csr(CSR_EXPECTED_CRC, 32'($urandom_range(0, 65535)));
            write_csr(CSR_UNPACKED_LENGTH, $urandom_range(32'h0010_0000, 32'hFFFF_FFFE));
         end
      end
      send_bytes(start_at, packed_stream.size());
      drain();

      if (pending_beats.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("lz_bitstream_decompressor_top regression: pass");
      end else begin
         $display("lz_bitstream_decompressor_top regression: fail");
      end
      $finish;
   end

endmodule
